// ===== hw/rtl/msp_pkg.sv =====
// msp_pkg: shared constants and command/status codes of the minimap square plotter
// used by minimap_square_plotter_unit; no dependencies

package msp_pkg;

    // minimap geometry and window border
    localparam int MAX_ROW_PIXELS    = 128;
    localparam int MAX_COLUMN_PIXELS = 128;
    localparam int BORDER_PERCENT    = 10;

    localparam int STORE_DEPTH = MAX_ROW_PIXELS * MAX_COLUMN_PIXELS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int USED_W      = $clog2(STORE_DEPTH + 1);
    localparam int MAX_PIX     = (MAX_ROW_PIXELS > MAX_COLUMN_PIXELS) ?
                                 MAX_ROW_PIXELS : MAX_COLUMN_PIXELS;
    localparam int PIX_W       = $clog2(MAX_PIX + 1);
    // paint coordinates reach past the minimap by up to half a unit, rounded up
    localparam int CO_W        = $clog2(MAX_PIX + 128);
    localparam int IDX_W       = $clog2((MAX_PIX + 128) * (MAX_PIX + 1));

    // shared multiplier, and the reciprocal used for the divide by 100
    localparam int MUL_A_W = 23;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int PCT_SH  = 32;
    localparam logic [MUL_B_W-1:0] PCT_RECIP =
        MUL_B_W'(((64'd1 << PCT_SH) + 64'd99) / 64'd100);

    localparam logic [7:0] PIXEL_EMPTY = 8'hFF;
    localparam logic [2:0] ZOOM_MIN    = 3'd1;
    localparam logic [2:0] ZOOM_MAX    = 3'd4;

    // stream widths
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 72;

    // commands
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_PLOT  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // result status
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_IGNORED = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_MAP_WIDTH   = 3'd0;
    localparam logic [2:0] REG_MAP_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_CLIP_LEFT   = 3'd2;
    localparam logic [2:0] REG_CLIP_TOP    = 3'd3;
    localparam logic [2:0] REG_CLIP_WIDTH  = 3'd4;
    localparam logic [2:0] REG_CLIP_HEIGHT = 3'd5;
    localparam logic [2:0] REG_ZOOM_LOG2   = 3'd6;

endpackage

// ===== hw/rtl/msp_ram.sv =====
// msp_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module msp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/minimap_square_plotter_unit.sv =====
// minimap_square_plotter_unit: top level, command sequencer around one shared multiplier
// depends on msp_pkg and msp_ram
//
// Usage: commands arrive on the s_ stream (tuser = command, tdata = operands), one
// result transaction leaves on the m_ stream for every command. Registers must be written
// over the cfg_ port only while the block is idle; the block itself does not enforce it.
// Start (cmd 0): setup steps (border, clamp, zoom, trim, area) then one store
// write per used pixel to fill it with 0xFF; a zero clip size answers as ignored
// with no setup and no fill.
// Plot (cmd 1): setup steps, then one store write per cell of the clipped
// square, (s+1)^2 cells for a unit of s >= 1 pixels and 4 for a smaller unit.
// Read (cmd 2): the pixel comes from the registered read of the pixel store.
// One command is in flight at a time; s_tready is high only when the sequencer idles.
// The finished result sits in an output register, so the next command is taken while
// the receiver stalls; a result that completes while the previous one is still held
// waits in the response state until m_tready frees the register.
// Reset clears the window and the sequencer; the pixel store holds no defined
// content until a start fills it, and no clearing pass runs after reset.

module minimap_square_plotter_unit
    import msp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write port
    input  logic                cfg_we,
    input  logic [2:0]          cfg_addr,
    input  logic [15:0]         cfg_wdata,
    // command stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // cell_x, cell_y, owner, unit_size, read_index
    input  logic [1:0]          s_tuser,   // cmd
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // region_left, region_top, row_pixels,
                                           // column_pixels, pixel_count, pixel
    output logic [1:0]          m_tuser    // status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PCT,
        S_DIV,
        S_EDGE,
        S_TRIM,
        S_AREA,
        S_COMMIT,
        S_CLEAR,
        S_PCHECK,
        S_PSETUP,
        S_PROW,
        S_PLOAD,
        S_PAINT,
        S_RADDR,
        S_RDATA,
        S_RESP
    } state_t;

    // configuration registers
    logic [15:0] map_width_reg, map_height_reg;
    logic [15:0] clip_left_reg, clip_top_reg, clip_width_reg, clip_height_reg;
    logic [2:0]  zoom_log2_reg;

    // control and window state
    state_t            state_reg;
    logic              m_valid_reg;
    logic              window_valid_reg;
    logic [15:0]       window_left_cells_reg, window_top_cells_reg;
    logic [15:0]       window_width_cells_reg, window_height_cells_reg;
    logic [USED_W-1:0] used_pixels_reg;
    logic [2:0]        latched_zoom_reg;

    // datapath registers
    logic [2:0]          start_z_reg;
    logic [MUL_P_W-1:0]  mul_p_reg;
    logic [15:0]         edge_l_reg, edge_t_reg, edge_r_reg, edge_b_reg;
    logic [PIX_W-1:0]    w_px_reg, h_px_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic [15:0]         cell_x_reg, cell_y_reg;
    logic [7:0]          owner_reg, unit_size_reg;
    logic [CO_W-1:0]     pos_x_reg, pos_y_reg;
    logic [CO_W-1:0]     lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg;
    logic [CO_W-1:0]     col_reg, row_reg;
    logic [IDX_W-1:0]    row_base_reg;
    logic [13:0]         rd_idx_reg;
    logic [1:0]          res_status_reg;
    logic [15:0]         res_left_reg, res_top_reg;
    logic [7:0]          res_row_reg, res_col_reg, res_pixel_reg;
    logic [14:0]         res_count_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    // combinational datapath
    logic [2:0]          zoom_eff;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [15:0]         extra_cells, map_w_eff, map_h_eff;
    logic [15:0]         edge_l, edge_t, edge_r, edge_b;
    logic [15:0]         span_w, span_h, trim_w, trim_h;
    logic [16:0]         dx, dy;
    logic                outside;
    logic [15:0]         pos_x, pos_y;
    logic [7:0]          size_px, size_eff, half;
    logic [CO_W-1:0]     lo_x, lo_y, hi_x, hi_y;
    logic [IDX_W-1:0]    paint_idx;
    logic                paint_hit;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [7:0]          ram_wdata, ram_rdata;
    logic                in_accept;

    // input fields
    logic [1:0]  in_cmd;
    logic [15:0] in_cell_x, in_cell_y;
    logic [7:0]  in_owner, in_unit_size;
    logic [13:0] in_read_index;

    assign in_cmd        = s_tuser;
    assign in_cell_x     = s_tdata[15:0];
    assign in_cell_y     = s_tdata[31:16];
    assign in_owner      = s_tdata[39:32];
    assign in_unit_size  = s_tdata[47:40];
    assign in_read_index = s_tdata[61:48];

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // low edge moved out by the border, clamped to [0, size-1]
    function automatic logic [15:0] clamp_lo(input logic [15:0] v, input logic [15:0] sub,
                                             input logic [15:0] size);
        logic [15:0] d;
        d = v - sub;
        if (v < sub) begin
            clamp_lo = '0;
        end else if (d >= size) begin
            clamp_lo = size - 16'd1;
        end else begin
            clamp_lo = d;
        end
    endfunction

    // high edge moved out by the border, clamped to size-1
    function automatic logic [15:0] clamp_hi(input logic [17:0] v, input logic [15:0] size);
        if (v >= {2'b00, size}) begin
            clamp_hi = size - 16'd1;
        end else begin
            clamp_hi = v[15:0];
        end
    endfunction

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg   <= 16'd1024;
            map_height_reg  <= 16'd1024;
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_width_reg  <= '0;
            clip_height_reg <= '0;
            zoom_log2_reg   <= ZOOM_MIN;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MAP_WIDTH:   map_width_reg   <= cfg_wdata;
                REG_MAP_HEIGHT:  map_height_reg  <= cfg_wdata;
                REG_CLIP_LEFT:   clip_left_reg   <= cfg_wdata;
                REG_CLIP_TOP:    clip_top_reg    <= cfg_wdata;
                REG_CLIP_WIDTH:  clip_width_reg  <= cfg_wdata;
                REG_CLIP_HEIGHT: clip_height_reg <= cfg_wdata;
                REG_ZOOM_LOG2:   zoom_log2_reg   <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // zoom limited to its legal range
    always_comb begin
        if (zoom_log2_reg inside {[ZOOM_MIN:ZOOM_MAX]}) begin
            zoom_eff = zoom_log2_reg;
        end else if (zoom_log2_reg < ZOOM_MIN) begin
            zoom_eff = ZOOM_MIN;
        end else begin
            zoom_eff = ZOOM_MAX;
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (state_reg)
            S_PCT: begin
                mul_a = MUL_A_W'(clip_width_reg);
                mul_b = MUL_B_W'(BORDER_PERCENT);
            end
            S_DIV: begin
                mul_a = mul_p_reg[MUL_A_W-1:0];
                mul_b = PCT_RECIP;
            end
            S_AREA: begin
                mul_a = MUL_A_W'(w_px_reg);
                mul_b = MUL_B_W'(h_px_reg);
            end
            S_PROW: begin
                mul_a = MUL_A_W'(lo_y_reg);
                mul_b = MUL_B_W'(w_px_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // window edges: border, clamp to map, scale by zoom
    always_comb begin
        extra_cells = mul_p_reg[PCT_SH +: 16];
        map_w_eff   = (map_width_reg == 16'd0) ? 16'd1 : map_width_reg;
        map_h_eff   = (map_height_reg == 16'd0) ? 16'd1 : map_height_reg;
        edge_l = clamp_lo(clip_left_reg, extra_cells, map_w_eff) >> start_z_reg;
        edge_t = clamp_lo(clip_top_reg, extra_cells, map_h_eff) >> start_z_reg;
        edge_r = clamp_hi(18'(clip_left_reg) + 18'(clip_width_reg) + 18'(extra_cells)
                          - 18'd1, map_w_eff) >> start_z_reg;
        edge_b = clamp_hi(18'(clip_top_reg) + 18'(clip_height_reg) + 18'(extra_cells)
                          - 18'd1, map_h_eff) >> start_z_reg;
    end

    // symmetric trim to the minimap limits
    always_comb begin
        span_w = edge_r_reg - edge_l_reg + 16'd1;
        span_h = edge_b_reg - edge_t_reg + 16'd1;
        if (span_w > 16'(MAX_ROW_PIXELS)) begin
            trim_w = (span_w - 16'(MAX_ROW_PIXELS) + 16'd1) >> 1;
        end else begin
            trim_w = '0;
        end
        if (span_h > 16'(MAX_COLUMN_PIXELS)) begin
            trim_h = (span_h - 16'(MAX_COLUMN_PIXELS) + 16'd1) >> 1;
        end else begin
            trim_h = '0;
        end
    end

    // plot: window hit test and square bounds
    always_comb begin
        dx      = {1'b0, cell_x_reg} - {1'b0, window_left_cells_reg};
        dy      = {1'b0, cell_y_reg} - {1'b0, window_top_cells_reg};
        outside = dx[16] || dy[16] || (dx[15:0] >= window_width_cells_reg)
                  || (dy[15:0] >= window_height_cells_reg);
        pos_x   = dx[15:0] >> latched_zoom_reg;
        pos_y   = dy[15:0] >> latched_zoom_reg;

        // a unit smaller than one pixel paints the same 2x2 block as a one-pixel unit
        size_px  = unit_size_reg >> latched_zoom_reg;
        size_eff = (size_px == 8'd0) ? 8'd1 : size_px;
        half     = size_eff >> 1;
        lo_x = (pos_x_reg >= CO_W'(half)) ? (pos_x_reg - CO_W'(half)) : '0;
        lo_y = (pos_y_reg >= CO_W'(half)) ? (pos_y_reg - CO_W'(half)) : '0;
        hi_x = pos_x_reg + CO_W'(size_eff - half);
        hi_y = pos_y_reg + CO_W'(size_eff - half);

        // linear index, may run into the next row; only the pixel count bounds it
        paint_idx = row_base_reg + IDX_W'(col_reg);
        paint_hit = paint_idx < IDX_W'(used_pixels_reg);
    end

    // pixel store write port
    always_comb begin
        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = PIXEL_EMPTY;
            end
            S_PAINT: begin
                ram_we    = paint_hit;
                ram_waddr = paint_idx[ADDR_W-1:0];
                ram_wdata = owner_reg;
            end
            default: begin
                ram_we    = 1'b0;
                ram_waddr = '0;
                ram_wdata = owner_reg;
            end
        endcase
    end

    msp_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // sequencer, window state and result registers
    always_ff @(posedge aclk) begin
        mul_p_reg <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
        if (!aresetn) begin
            state_reg               <= S_IDLE;
            m_valid_reg             <= 1'b0;
            window_valid_reg        <= 1'b0;
            window_left_cells_reg   <= '0;
            window_top_cells_reg    <= '0;
            window_width_cells_reg  <= '0;
            window_height_cells_reg <= '0;
            used_pixels_reg         <= '0;
            latched_zoom_reg        <= ZOOM_MIN;
        end else begin
            // the response state reloads the register itself
            if (m_valid_reg && m_tready && state_reg != S_RESP) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_accept) begin
                        res_left_reg   <= '0;
                        res_top_reg    <= '0;
                        res_row_reg    <= '0;
                        res_col_reg    <= '0;
                        res_count_reg  <= '0;
                        res_pixel_reg  <= '0;
                        cell_x_reg     <= in_cell_x;
                        cell_y_reg     <= in_cell_y;
                        owner_reg      <= in_owner;
                        unit_size_reg  <= in_unit_size;
                        rd_idx_reg     <= in_read_index;
                        start_z_reg    <= zoom_eff;
                        case (in_cmd)
                            CMD_START: begin
                                if (clip_width_reg == 16'd0 || clip_height_reg == 16'd0) begin
                                    window_valid_reg        <= 1'b0;
                                    used_pixels_reg         <= '0;
                                    window_left_cells_reg   <= '0;
                                    window_top_cells_reg    <= '0;
                                    window_width_cells_reg  <= '0;
                                    window_height_cells_reg <= '0;
                                    res_status_reg          <= STATUS_IGNORED;
                                    state_reg               <= S_RESP;
                                end else begin
                                    res_status_reg <= STATUS_DONE;
                                    state_reg      <= S_PCT;
                                end
                            end
                            CMD_PLOT: begin
                                if (!window_valid_reg) begin
                                    res_status_reg <= STATUS_IGNORED;
                                    state_reg      <= S_RESP;
                                end else begin
                                    res_status_reg <= STATUS_DONE;
                                    state_reg      <= S_PCHECK;
                                end
                            end
                            CMD_READ: begin
                                if (USED_W'(in_read_index) >= used_pixels_reg) begin
                                    res_status_reg <= STATUS_RANGE;
                                    state_reg      <= S_RESP;
                                end else begin
                                    res_status_reg <= STATUS_DONE;
                                    state_reg      <= S_RADDR;
                                end
                            end
                            default: begin
                                res_status_reg <= STATUS_IGNORED;
                                state_reg      <= S_RESP;
                            end
                        endcase
                    end
                end
                // width times percent, then times the reciprocal of 100
                S_PCT: state_reg <= S_DIV;
                S_DIV: state_reg <= S_EDGE;
                S_EDGE: begin
                    edge_l_reg <= edge_l;
                    edge_t_reg <= edge_t;
                    edge_r_reg <= edge_r;
                    edge_b_reg <= edge_b;
                    state_reg  <= S_TRIM;
                end
                S_TRIM: begin
                    edge_l_reg <= edge_l_reg + trim_w;
                    edge_t_reg <= edge_t_reg + trim_h;
                    w_px_reg   <= PIX_W'(span_w - (trim_w << 1));
                    h_px_reg   <= PIX_W'(span_h - (trim_h << 1));
                    state_reg  <= S_AREA;
                end
                S_AREA: state_reg <= S_COMMIT;
                S_COMMIT: begin
                    used_pixels_reg         <= USED_W'(mul_p_reg);
                    latched_zoom_reg        <= start_z_reg;
                    window_valid_reg        <= 1'b1;
                    window_left_cells_reg   <= edge_l_reg << start_z_reg;
                    window_top_cells_reg    <= edge_t_reg << start_z_reg;
                    window_width_cells_reg  <= 16'(w_px_reg) << start_z_reg;
                    window_height_cells_reg <= 16'(h_px_reg) << start_z_reg;
                    res_left_reg            <= edge_l_reg << start_z_reg;
                    res_top_reg             <= edge_t_reg << start_z_reg;
                    res_row_reg             <= 8'(w_px_reg);
                    res_col_reg             <= 8'(h_px_reg);
                    res_count_reg           <= 15'(mul_p_reg);
                    clr_cnt_reg             <= '0;
                    state_reg               <= S_CLEAR;
                end
                // fill the used part of the store, one pixel a cycle
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    if (clr_cnt_reg == ADDR_W'(used_pixels_reg - USED_W'(1))) begin
                        state_reg <= S_RESP;
                    end
                end
                S_PCHECK: begin
                    pos_x_reg <= CO_W'(pos_x);
                    pos_y_reg <= CO_W'(pos_y);
                    if (outside) begin
                        res_status_reg <= STATUS_IGNORED;
                        state_reg      <= S_RESP;
                    end else begin
                        state_reg <= S_PSETUP;
                    end
                end
                S_PSETUP: begin
                    lo_x_reg  <= lo_x;
                    lo_y_reg  <= lo_y;
                    hi_x_reg  <= hi_x;
                    hi_y_reg  <= hi_y;
                    state_reg <= S_PROW;
                end
                S_PROW: state_reg <= S_PLOAD;
                S_PLOAD: begin
                    row_base_reg <= IDX_W'(mul_p_reg);
                    col_reg      <= lo_x_reg;
                    row_reg      <= lo_y_reg;
                    state_reg    <= S_PAINT;
                end
                // raster over the square, one pixel a cycle
                S_PAINT: begin
                    if (col_reg == hi_x_reg) begin
                        col_reg      <= lo_x_reg;
                        row_reg      <= row_reg + CO_W'(1);
                        row_base_reg <= row_base_reg + IDX_W'(w_px_reg);
                        if (row_reg == hi_y_reg) begin
                            state_reg <= S_RESP;
                        end
                    end else begin
                        col_reg <= col_reg + CO_W'(1);
                    end
                end
                S_RADDR: state_reg <= S_RDATA;
                S_RDATA: begin
                    res_pixel_reg <= ram_rdata;
                    state_reg     <= S_RESP;
                end
                // hand the result to the output register once it is free
                S_RESP: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_tuser_reg <= res_status_reg;
                        m_tdata_reg <= {1'b0, res_pixel_reg, res_count_reg, res_col_reg,
                                        res_row_reg, res_top_reg, res_left_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // every store write stays inside the used pixels
    a_write_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (USED_W'(ram_waddr) < used_pixels_reg))
        else $error("store write beyond used pixel count");

    // a valid window always covers at least one pixel and fits the store
    a_window_size: assert property (@(posedge aclk) disable iff (!aresetn)
        window_valid_reg |-> (used_pixels_reg != '0)
                             && (used_pixels_reg <= USED_W'(STORE_DEPTH)))
        else $error("valid window with bad pixel count");

    // one command at a time: busy right after an accepted transaction
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("command accepted while busy");

    // latched zoom stays in range
    a_zoom_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (latched_zoom_reg >= ZOOM_MIN) && (latched_zoom_reg <= ZOOM_MAX))
        else $error("latched zoom out of range");

    // a result is only loaded while the output register is free or draining
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP && m_valid_reg && !m_tready) |=> m_valid_reg
                                                            && (state_reg == S_RESP))
        else $error("result overwritten while held");
`endif

endmodule
